// ----- sv/nfsa_pkg.sv -----
// Shared types, constants and helpers for the next-fit slot allocator.
// No dependencies; imported by every module of the allocator.
package nfsa_pkg;

    localparam int SLOTS  = 1024;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SLOT_W = 11;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_FULL    = 2'd1,
        ST_FREED   = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // Advance a slot index by one, wrapping at the pool size
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(SLOTS - 1))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

endpackage

// ----- sv/nfsa_used_mem.sv -----
// Used-bit memory of the slot allocator: one write port, one read port,
// read data registered. Depends on nfsa_pkg.
module nfsa_used_mem
    import nfsa_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output logic     rd_data
);

    logic mem [SLOTS];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/nfsa_seq.sv -----
// Sequencer of the slot allocator: clearing pass, free requests and the
// one-slot-per-cycle next-fit scan over the used-bit memory. Depends on nfsa_pkg.
module nfsa_seq
    import nfsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_accept,
    input  opcode_t           req_op,
    input  logic [SLOT_W-1:0] req_slot,
    input  logic              rd_data,
    input  logic              out_free,
    output logic              idle,
    output mem_req_t          mem_req,
    output logic              res_valid,
    output status_t           res_status,
    output logic [SLOT_W-1:0] res_slot
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              chk_vld_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              chk_last_reg;
    logic [IDX_W-1:0]  clr_reg;
    status_t           res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;

    logic              slot_good;
    logic [IDX_W-1:0]  free_idx;
    logic              found;
    logic              exhausted;

    assign slot_good = (req_slot != '0) && (32'(req_slot) <= 32'(SLOTS));
    assign free_idx  = IDX_W'(req_slot - 1'b1);
    assign found     = chk_vld_reg && !rd_data;
    assign exhausted = chk_vld_reg && rd_data && chk_last_reg;

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = 1'b0;
            end
            S_IDLE:
            begin
                if (req_accept && req_op == OP_FREE && slot_good)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = free_idx;
                    mem_req.wdata = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = chk_idx_reg;
                    mem_req.wdata = 1'b1;
                end
                else if (!exhausted && rem_reg != '0)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = addr_reg;
                end
            end
            S_RESP:
            begin
                mem_req = '0;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            addr_reg       <= '0;
            rem_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            chk_last_reg   <= 1'b0;
            clr_reg        <= '0;
            res_status_reg <= ST_GRANTED;
            res_slot_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= next_idx(clr_reg);
                    if (clr_reg == IDX_W'(SLOTS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        if (req_op == OP_ALLOC)
                        begin
                            addr_reg    <= ptr_reg;
                            rem_reg     <= CNT_W'(SLOTS);
                            chk_vld_reg <= 1'b0;
                            state_reg   <= S_SCAN;
                        end
                        else
                        begin
                            res_status_reg <= slot_good ? ST_FREED : ST_BAD;
                            res_slot_reg   <= '0;
                            state_reg      <= S_RESP;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (found)
                    begin
                        ptr_reg        <= next_idx(chk_idx_reg);
                        res_status_reg <= ST_GRANTED;
                        res_slot_reg   <= SLOT_W'({1'b0, chk_idx_reg} + 1'b1);
                        chk_vld_reg    <= 1'b0;
                        state_reg      <= S_RESP;
                    end
                    else if (exhausted)
                    begin
                        // pool full: pointer still steps on by one
                        ptr_reg        <= next_idx(ptr_reg);
                        res_status_reg <= ST_FULL;
                        res_slot_reg   <= '0;
                        chk_vld_reg    <= 1'b0;
                        state_reg      <= S_RESP;
                    end
                    else if (rem_reg != '0)
                    begin
                        chk_vld_reg  <= 1'b1;
                        chk_idx_reg  <= addr_reg;
                        chk_last_reg <= (rem_reg == CNT_W'(1));
                        addr_reg     <= next_idx(addr_reg);
                        rem_reg      <= rem_reg - 1'b1;
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP) && out_free;
    assign res_status = res_status_reg;
    assign res_slot   = res_slot_reg;

endmodule

// ----- sv/next_fit_slot_allocator.sv -----
// Next-fit slot allocator, top level. Free: a valid slot's used bit is cleared at
// acceptance. Allocate: the scan reads one used bit a cycle from the search pointer
// to the first free slot; with all SLOTS (1024) used it reports pool full. One word
// at a time; the output register lets a new word in while a result waits.
// Reset (rst_n, async, active low) clears every used bit, s_tready low throughout.
// Depends on nfsa_pkg, nfsa_seq, nfsa_used_mem.
module next_fit_slot_allocator
    import nfsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] slot_in, [15:11] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] slot_out, [15:11] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic              accept;
    logic              idle;
    logic              rd_data;
    logic              out_free;
    logic              res_valid;
    status_t           res_status;
    logic [SLOT_W-1:0] res_slot;
    mem_req_t          mem_req;

    logic              out_vld_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    nfsa_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_accept (accept),
        .req_op     (opcode_t'(s_tuser[0])),
        .req_slot   (s_tdata[SLOT_W-1:0]),
        .rd_data    (rd_data),
        .out_free   (out_free),
        .idle       (idle),
        .mem_req    (mem_req),
        .res_valid  (res_valid),
        .res_status (res_status),
        .res_slot   (res_slot)
    );

    nfsa_used_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (res_valid)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = 16'(out_slot_reg);
    assign m_tuser  = out_status_reg;

    // one word at a time: nothing more taken in the cycle after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in progress");

    // a grant always names a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_GRANTED) |-> (m_tdata[SLOT_W-1:0] != '0))
        else $error("grant without a slot number");

    // no slot number unless granted
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_GRANTED) |-> (m_tdata[SLOT_W-1:0] == '0))
        else $error("slot number on a non-grant result");

    // a new result never lands on one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tuser) && $stable(m_tdata)))
        else $error("waiting result overwritten");

endmodule
